FILE: sv/lbmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lucas binomial package
// Shared widths and defaults for the binomial-mod-prime block.
// ----------------------------------------------------------------------------
package lbmp_pkg;

    // Width of a residue, of a table entry and of the modulus register.
    localparam int VAL_W = 17;

    localparam int DEF_TABLE_DEPTH = 131072;
    localparam int DEF_ARG_BITS    = 48;

    localparam logic [VAL_W-1:0] MOD_RESET = 17'd2;

    // Request kind carried in the input tuser.
    typedef enum logic {
        KIND_REBUILD = 1'b0,
        KIND_QUERY   = 1'b1
    } kind_t;

endpackage

FILE: sv/lbmp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Divides a wide dividend by the modulus one bit per cycle, giving the
// quotient and a remainder below the modulus.
// ----------------------------------------------------------------------------
module lbmp_divider #(
    parameter int DW = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [lbmp_pkg::VAL_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [DW-1:0]               quot,
    output logic [lbmp_pkg::VAL_W-1:0]  rem
);

    localparam int VW = lbmp_pkg::VAL_W;
    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   trial;
    logic          qbit;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DW-1]};
        qbit      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The trial value stays below twice the divisor, so one subtract suffices.
            rem_next = qbit ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
            dvd_next = {dvd_reg[DW-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule

FILE: sv/lucas_binomial_mod_prime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial coefficient modulo a prime
// Factorial table rebuild and Lucas-theorem queries over a table memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: kind; tdata: top, choose
// m_axis    out        tuser: was_rebuild; tdata: residue
// cfg       in         modulus
//
// Every modular product takes one multiply and a DW-bit restoring
// reduction (DW = max(ARG_BITS, 34)). A rebuild takes one modular product
// per table entry 1 to p-1. A query takes, per base-p digit of choose,
// two divisions for the digit split and three table reads, plus 20 to 36
// modular products for the Fermat inverse and accumulation.
// Reset holds no table clear; a query needs a prior rebuild for its modulus.
// A new request is taken in the idle state even while a result waits.
// ----------------------------------------------------------------------------
module lucas_binomial_mod_prime #(
    parameter int TABLE_DEPTH = lbmp_pkg::DEF_TABLE_DEPTH,
    parameter int ARG_BITS    = lbmp_pkg::DEF_ARG_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: top [ARG_BITS-1:0], choose above it, zero padded
    input  logic [((2*ARG_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: kind
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: residue [16:0], zero padded
    output logic [23:0]                           m_axis_tdata,
    // tuser: was_rebuild
    output logic                                  m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lbmp_pkg::VAL_W-1:0]            cfg_data
);

    localparam int VW = lbmp_pkg::VAL_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = (ARG_BITS > 2*VW) ? ARG_BITS : 2*VW;
    localparam int CMPW = (AW + 1 > VW) ? AW + 1 : VW;
    localparam int IW = $clog2(VW);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_QCHK  = 13'b0000000000010,
        S_DIVN  = 13'b0000000000100,
        S_DIVM  = 13'b0000000001000,
        S_RD1   = 13'b0000000010000,
        S_RD2   = 13'b0000000100000,
        S_RD3   = 13'b0000001000000,
        S_RD4   = 13'b0000010000000,
        S_MUL   = 13'b0000100000000,
        S_MDIV  = 13'b0001000000000,
        S_MWAIT = 13'b0010000000000,
        S_EXP   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    typedef enum logic [2:0] {
        ST_BUILD,
        ST_DEN,
        ST_SQ,
        ST_EXPMUL,
        ST_FAC,
        ST_ACC
    } step_t;

    state_t                state_reg, state_next;
    step_t                 step_reg, step_next;
    logic [VW-1:0]         modulus_reg;
    logic [VW-1:0]         p_eff;
    logic [ARG_BITS-1:0]   n_reg, n_next, m_reg, m_next;
    logic [VW-1:0]         nd_reg, nd_next, md_reg, md_next;
    logic [VW-1:0]         fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic [VW-1:0]         acc_reg, acc_next, r_reg, r_next, base_reg, base_next;
    logic [VW-1:0]         e_reg, e_next, k_reg, k_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [VW-1:0]         mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [2*VW-1:0]       prod_reg;
    logic [VW-1:0]         res_reg, res_next;
    logic                  rebuild_reg, rebuild_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VW-1:0]         out_res_reg, out_res_next;
    logic                  out_rebuild_reg, out_rebuild_next;

    logic [VW-1:0]         table_mem [TABLE_DEPTH];
    logic [VW-1:0]         rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [VW-1:0]         mem_wdata;

    logic                  div_start, div_busy, div_done;
    logic [DW-1:0]         div_dividend, div_quot;
    logic [VW-1:0]         div_rem;

    logic                  in_accept;
    logic [VW-1:0]         r_new;
    logic                  go_next_bit;

    // Modulus clamped into the range the table can hold.
    always_comb
    begin
        if (modulus_reg < VW'(2))
            p_eff = VW'(2);
        else if (CMPW'(modulus_reg) > CMPW'(TABLE_DEPTH - 1))
            p_eff = VW'(TABLE_DEPTH - 1);
        else
            p_eff = modulus_reg;
    end

    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    lbmp_divider #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (p_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        n_next           = n_reg;
        m_next           = m_reg;
        nd_next          = nd_reg;
        md_next          = md_reg;
        fa_next          = fa_reg;
        fb_next          = fb_reg;
        fc_next          = fc_reg;
        acc_next         = acc_reg;
        r_next           = r_reg;
        base_next        = base_reg;
        e_next           = e_reg;
        k_next           = k_reg;
        idx_next         = idx_reg;
        mul_a_next       = mul_a_reg;
        mul_b_next       = mul_b_reg;
        res_next         = res_reg;
        rebuild_next     = rebuild_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_res_next     = out_res_reg;
        out_rebuild_next = out_rebuild_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = div_rem;
        mem_raddr        = '0;
        div_start        = 1'b0;
        div_dividend     = DW'(prod_reg);
        r_new            = r_reg;
        go_next_bit      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == lbmp_pkg::KIND_REBUILD)
                    begin
                        // Entry zero holds 0! = 1; the walk starts at k = 1.
                        mem_we       = 1'b1;
                        mem_waddr    = '0;
                        mem_wdata    = VW'(1);
                        k_next       = VW'(1);
                        mul_a_next   = VW'(1);
                        mul_b_next   = VW'(1);
                        step_next    = ST_BUILD;
                        rebuild_next = 1'b1;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        n_next       = s_axis_tdata[ARG_BITS-1:0];
                        m_next       = s_axis_tdata[2*ARG_BITS-1:ARG_BITS];
                        acc_next     = VW'(1);
                        rebuild_next = 1'b0;
                        state_next   = S_QCHK;
                    end
                end
            end
            S_QCHK:
            begin
                if (m_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(n_reg);
                    state_next   = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    nd_next      = div_rem;
                    n_next       = div_quot[ARG_BITS-1:0];
                    div_start    = 1'b1;
                    div_dividend = DW'(m_reg);
                    state_next   = S_DIVM;
                end
            end
            S_DIVM:
            begin
                if (div_done)
                begin
                    md_next    = div_rem;
                    m_next     = div_quot[ARG_BITS-1:0];
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                if (md_reg > nd_reg)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = AW'(md_reg);
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                fa_next    = rdata_reg;
                mem_raddr  = AW'(nd_reg - md_reg);
                state_next = S_RD3;
            end
            S_RD3:
            begin
                fb_next    = rdata_reg;
                mem_raddr  = AW'(nd_reg);
                state_next = S_RD4;
            end
            S_RD4:
            begin
                fc_next    = rdata_reg;
                mul_a_next = fa_reg;
                mul_b_next = fb_reg;
                step_next  = ST_DEN;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                div_start  = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (div_done)
                begin
                    case (step_reg)
                        ST_BUILD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(k_reg);
                            if (k_reg == p_eff - VW'(1))
                            begin
                                res_next   = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                k_next     = k_reg + VW'(1);
                                mul_a_next = div_rem;
                                mul_b_next = k_reg + VW'(1);
                                state_next = S_MUL;
                            end
                        end
                        ST_DEN:
                        begin
                            // Fermat inverse: scan p-2 from the top bit down.
                            base_next  = div_rem;
                            r_next     = VW'(1);
                            e_next     = p_eff - VW'(2);
                            idx_next   = IW'(VW - 1);
                            state_next = S_EXP;
                        end
                        ST_SQ:
                        begin
                            r_new  = div_rem;
                            r_next = div_rem;
                            if (e_reg[idx_reg])
                            begin
                                mul_a_next = div_rem;
                                mul_b_next = base_reg;
                                step_next  = ST_EXPMUL;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                go_next_bit = 1'b1;
                            end
                        end
                        ST_EXPMUL:
                        begin
                            r_new       = div_rem;
                            r_next      = div_rem;
                            go_next_bit = 1'b1;
                        end
                        ST_FAC:
                        begin
                            mul_a_next = acc_reg;
                            mul_b_next = div_rem;
                            step_next  = ST_ACC;
                            state_next = S_MUL;
                        end
                        ST_ACC:
                        begin
                            acc_next   = div_rem;
                            state_next = S_QCHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    if (go_next_bit)
                    begin
                        if (idx_reg == '0)
                        begin
                            mul_a_next = fc_reg;
                            mul_b_next = r_new;
                            step_next  = ST_FAC;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            idx_next   = idx_reg - IW'(1);
                            state_next = S_EXP;
                        end
                    end
                end
            end
            S_EXP:
            begin
                mul_a_next = r_reg;
                mul_b_next = r_reg;
                step_next  = ST_SQ;
                state_next = S_MUL;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_res_next     = res_reg;
                    out_rebuild_next = rebuild_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_BUILD;
            modulus_reg   <= lbmp_pkg::MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                modulus_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        m_reg           <= m_next;
        nd_reg          <= nd_next;
        md_reg          <= md_next;
        fa_reg          <= fa_next;
        fb_reg          <= fb_next;
        fc_reg          <= fc_next;
        acc_reg         <= acc_next;
        r_reg           <= r_next;
        base_reg        <= base_next;
        e_reg           <= e_next;
        k_reg           <= k_next;
        idx_reg         <= idx_next;
        mul_a_reg       <= mul_a_next;
        mul_b_reg       <= mul_b_next;
        prod_reg        <= mul_a_reg * mul_b_reg;
        res_reg         <= res_next;
        rebuild_reg     <= rebuild_next;
        out_res_reg     <= out_res_next;
        out_rebuild_reg <= out_rebuild_next;
    end

    // Factorial table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= table_mem[mem_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24 - VW){1'b0}}, out_res_reg};
    assign m_axis_tuser  = out_rebuild_reg;

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_write_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE) || (step_reg == ST_BUILD))
        else $error("table written outside a rebuild");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MWAIT) || (state_reg == S_DIVN)
                     || (state_reg == S_DIVM))
        else $error("divider result with no consumer");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
